>>> rtl/unsigned_alu_div_pow_top_macros.svh
// assertion macros for the unsigned alu
`ifndef UNSIGNED_ALU_DIV_POW_TOP_MACROS_SVH
`define UNSIGNED_ALU_DIV_POW_TOP_MACROS_SVH

// implication checked on every clock edge outside reset
`define UADP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UADP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/uadp_pkg.sv
// shared types and constants for the unsigned alu
package uadp_pkg;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRACTION_WIDTH_DEF = 32;
    localparam int OPCODE_WIDTH = 3;

    typedef enum logic [OPCODE_WIDTH-1:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_FRAC = 3'd4,
        OP_POW  = 3'd5
    } opcode_t;
endpackage

>>> rtl/uadp_if.sv
// valid/ready channel carrying one payload
interface uadp_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/unsigned_alu_div_pow_top.sv
// Unsigned ALU top level. One request carries operand_a, operand_b and an
// opcode and yields one response. Add and subtract are computed at accept
// and pass from the done state into the response register. Multiply runs
// a bit-serial shift-and-add unit. Divide runs a restoring divider one
// quotient bit per cycle; fraction continues for FRACTION_WIDTH more bits.
// Power uses square-and-multiply over the DATA_WIDTH exponent bits, with
// a multiplier pass for each set bit and a squaring pass for each bit but
// the last. One request is in flight at a time; the next is accepted as
// soon as the response register is handed off or even while it waits,
// once the engine is free. A finished result waits in the engine while an
// earlier response is still unaccepted. Zero divisor gives zeros and the
// divide_by_zero flag. Unused opcodes give all zeros.
module unsigned_alu_div_pow_top #(
    parameter int DATA_WIDTH     = uadp_pkg::DATA_WIDTH_DEF,
    parameter int FRACTION_WIDTH = uadp_pkg::FRACTION_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    uadp_if.sink   req,
    uadp_if.source rsp
);
    `include "unsigned_alu_div_pow_top_macros.svh"

    localparam int EW = $clog2(DATA_WIDTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN_DIV,
        S_RUN_MUL,
        S_POW_MUL,
        S_POW_SQR,
        S_DONE
    } state_t;

    state_t state_reg;
    logic [DATA_WIDTH-1:0]     a_reg;
    logic [DATA_WIDTH-1:0]     b_reg;
    logic [DATA_WIDTH-1:0]     acc_reg;
    logic [EW-1:0]             ebits_reg;
    logic [DATA_WIDTH-1:0]     res_reg;
    logic [FRACTION_WIDTH-1:0] frac_reg;
    logic                      dz_reg;
    logic                      wait_reg;
    logic                      out_valid_reg;
    logic [31:0]               out_res_reg;
    logic [31:0]               out_frac_reg;
    logic                      out_dz_reg;

    logic                      mul_start;
    logic [DATA_WIDTH-1:0]     mul_x;
    logic [DATA_WIDTH-1:0]     mul_y;
    logic                      mul_busy;
    logic [DATA_WIDTH-1:0]     mul_p;
    logic                      div_start;
    logic                      div_frac;
    logic                      div_busy;
    logic [DATA_WIDTH-1:0]     div_q;
    logic [FRACTION_WIDTH-1:0] div_f;
    logic                      accept;
    logic                      out_take;
    logic                      frac_mode_reg;
    logic [DATA_WIDTH-1:0]     in_a;
    logic [DATA_WIDTH-1:0]     in_b;
    uadp_pkg::opcode_t         in_op;

    assign in_a  = DATA_WIDTH'(req.payload.operand_a);
    assign in_b  = DATA_WIDTH'(req.payload.operand_b);
    assign in_op = uadp_pkg::opcode_t'(req.payload.opcode);

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_take  = rsp.valid && rsp.ready;

    // result register; engine finishes into it when it is free
    assign rsp.valid                 = out_valid_reg;
    assign rsp.payload.result_value  = out_res_reg;
    assign rsp.payload.fraction_part = out_frac_reg;
    assign rsp.payload.divide_by_zero = out_dz_reg;

    uadp_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .x(mul_x), .y(mul_y),
        .busy(mul_busy), .product(mul_p)
    );

    uadp_div #(.DATA_WIDTH(DATA_WIDTH), .FRACTION_WIDTH(FRACTION_WIDTH)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .with_frac(div_frac),
        .dividend(a_reg), .divisor(b_reg), .busy(div_busy),
        .quotient(div_q), .fraction(div_f)
    );

    // launch units in the cycle after accept (operands registered first)
    always_comb
    begin
        mul_start = 1'b0;
        mul_x     = a_reg;
        mul_y     = b_reg;
        div_start = 1'b0;
        div_frac  = frac_mode_reg;
        if (!wait_reg)
        begin
            unique case (state_reg)
                S_RUN_DIV: div_start = 1'b1;
                S_RUN_MUL: mul_start = 1'b1;
                S_POW_MUL:
                begin
                    mul_start = 1'b1;
                    mul_x     = acc_reg;
                    mul_y     = a_reg;
                end
                S_POW_SQR:
                begin
                    // no squaring pass after the last exponent bit
                    mul_start = (ebits_reg != EW'(1));
                    mul_x     = a_reg;
                    mul_y     = a_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            frac_mode_reg <= 1'b0;
        end
        else
        begin
            // a handoff in the done state reloads the register instead
            if (out_take && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        a_reg         <= in_a;
                        b_reg         <= in_b;
                        acc_reg       <= DATA_WIDTH'(1);
                        ebits_reg     <= EW'(DATA_WIDTH);
                        res_reg       <= '0;
                        frac_reg      <= '0;
                        dz_reg        <= 1'b0;
                        wait_reg      <= 1'b0;
                        frac_mode_reg <= (in_op == uadp_pkg::OP_FRAC);
                        unique case (in_op) inside
                            uadp_pkg::OP_ADD:
                            begin
                                res_reg   <= in_a + in_b;
                                state_reg <= S_DONE;
                            end
                            uadp_pkg::OP_SUB:
                            begin
                                res_reg   <= in_a - in_b;
                                state_reg <= S_DONE;
                            end
                            uadp_pkg::OP_MUL: state_reg <= S_RUN_MUL;
                            uadp_pkg::OP_DIV, uadp_pkg::OP_FRAC:
                            begin
                                if (in_b == '0)
                                begin
                                    dz_reg    <= 1'b1;
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_RUN_DIV;
                                end
                            end
                            uadp_pkg::OP_POW:
                                state_reg <= in_b[0] ? S_POW_MUL : S_POW_SQR;
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_RUN_MUL:
                begin
                    if (!wait_reg)
                    begin
                        wait_reg <= 1'b1;
                    end
                    else if (!mul_busy)
                    begin
                        wait_reg  <= 1'b0;
                        res_reg   <= mul_p;
                        state_reg <= S_DONE;
                    end
                end
                S_RUN_DIV:
                begin
                    if (!wait_reg)
                    begin
                        wait_reg <= 1'b1;
                    end
                    else if (!div_busy)
                    begin
                        wait_reg  <= 1'b0;
                        res_reg   <= div_q;
                        frac_reg  <= div_f;
                        state_reg <= S_DONE;
                    end
                end
                S_POW_MUL:
                begin
                    if (!wait_reg)
                    begin
                        wait_reg <= 1'b1;
                    end
                    else if (!mul_busy)
                    begin
                        wait_reg  <= 1'b0;
                        acc_reg   <= mul_p;
                        state_reg <= S_POW_SQR;
                    end
                end
                S_POW_SQR:
                begin
                    // squaring after the last exponent bit is not needed
                    if (ebits_reg == EW'(1))
                    begin
                        res_reg   <= acc_reg;
                        wait_reg  <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else if (!wait_reg)
                    begin
                        wait_reg <= 1'b1;
                    end
                    else if (!mul_busy)
                    begin
                        wait_reg  <= 1'b0;
                        a_reg     <= mul_p;
                        b_reg     <= {1'b0, b_reg[DATA_WIDTH-1:1]};
                        ebits_reg <= ebits_reg - 1'b1;
                        state_reg <= b_reg[1] ? S_POW_MUL : S_POW_SQR;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_take)
                    begin
                        out_valid_reg <= 1'b1;
                        out_res_reg   <= 32'(res_reg);
                        out_frac_reg  <= 32'(frac_reg);
                        out_dz_reg    <= dz_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `UADP_ASSERT_IMPL(a_no_dual_start, clk, rst_n, mul_start, !div_start,
        "both units started together")
    `UADP_ASSERT_NEXT(a_dz_zero, clk, rst_n, rsp.valid && rsp.payload.divide_by_zero,
        !rsp.valid || rsp.payload.divide_by_zero || $past(out_take),
        "flag dropped without handoff")
    `UADP_ASSERT_IMPL(a_idle_units, clk, rst_n, state_reg == S_IDLE,
        !mul_busy && !div_busy, "unit busy while idle")
endmodule

>>> rtl/uadp_mul.sv
// shift-and-add multiplier, one multiplier bit per cycle, low product bits only
module uadp_mul #(
    parameter int DATA_WIDTH = uadp_pkg::DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] x,
    input  logic [DATA_WIDTH-1:0] y,
    output logic                  busy,
    output logic [DATA_WIDTH-1:0] product
);
    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] mcand_reg;
    logic [DATA_WIDTH-1:0] mplier_reg;
    logic [DATA_WIDTH-1:0] acc_reg;
    logic [CW-1:0]         cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CW'(DATA_WIDTH);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= x;
            mplier_reg <= y;
            acc_reg    <= '0;
        end
        else if (cnt_reg != '0)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[DATA_WIDTH-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[DATA_WIDTH-1:1]};
        end
    end

    assign busy    = (cnt_reg != '0);
    assign product = acc_reg;
endmodule

>>> rtl/uadp_div.sv
// restoring divider, one quotient bit per cycle, integer then fraction bits
module uadp_div #(
    parameter int DATA_WIDTH     = uadp_pkg::DATA_WIDTH_DEF,
    parameter int FRACTION_WIDTH = uadp_pkg::FRACTION_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      with_frac,
    input  logic [DATA_WIDTH-1:0]     dividend,
    input  logic [DATA_WIDTH-1:0]     divisor,
    output logic                      busy,
    output logic [DATA_WIDTH-1:0]     quotient,
    output logic [FRACTION_WIDTH-1:0] fraction
);
    localparam int TW = DATA_WIDTH + FRACTION_WIDTH;
    localparam int CW = $clog2(TW + 1);

    // dividend bits shift out at the top, zeros follow for fraction bits
    logic [TW-1:0]         num_reg;
    logic [TW-1:0]         quo_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] den_reg;
    logic [CW-1:0]         cnt_reg;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH:0]   diff;

    assign trial = {rem_reg, num_reg[TW-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= with_frac ? CW'(TW) : CW'(DATA_WIDTH);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {dividend, {FRACTION_WIDTH{1'b0}}};
            quo_reg <= '0;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            num_reg <= {num_reg[TW-2:0], 1'b0};
            if (!diff[DATA_WIDTH])
            begin
                rem_reg <= diff[DATA_WIDTH-1:0];
                quo_reg <= {quo_reg[TW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DATA_WIDTH-1:0];
                quo_reg <= {quo_reg[TW-2:0], 1'b0};
            end
        end
    end

    assign busy = (cnt_reg != '0);
    // integer mode stops early: quotient then sits in the low bits
    always_comb
    begin
        if (with_frac)
        begin
            quotient = quo_reg[TW-1:FRACTION_WIDTH];
            fraction = quo_reg[FRACTION_WIDTH-1:0];
        end
        else
        begin
            quotient = quo_reg[DATA_WIDTH-1:0];
            fraction = '0;
        end
    end
endmodule

>>> test/unsigned_alu_div_pow_top_tb.sv
// self-checking testbench for the unsigned alu with divide, fraction and power
module unsigned_alu_div_pow_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  DW           = 32;
    localparam int  FW           = 32;
    localparam int  RANDOM_ITEMS = 1430;
    localparam int  CYCLE_LIMIT  = 40_000_000;
    // a power request can keep the engine busy this long
    localparam int  DRAIN_CYCLES = 2 * DW * (DW + 2) + 64;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam logic [DW-1:0] ALL_ONES = {DW{1'b1}};

    typedef struct packed {
        logic [DW-1:0] operand_a;
        logic [DW-1:0] operand_b;
        logic [2:0]    opcode;
    } alu_request_t;

    typedef struct packed {
        logic [DW-1:0] result_value;
        logic [FW-1:0] fraction_part;
        logic          divide_by_zero;
    } alu_result_t;

    // one row of the directed table; fixed rows carry a hand-written answer
    typedef struct {
        alu_request_t req;
        bit           fixed;
        alu_result_t  answer;
    } vector_row_t;

    logic clk;
    logic rst_n;

    uadp_if #(.payload_t(alu_request_t)) req_ch ();
    uadp_if #(.payload_t(alu_result_t))  rsp_ch ();

    unsigned_alu_div_pow_top #(
        .DATA_WIDTH     (DW),
        .FRACTION_WIDTH (FW)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // answers still owed by the block, oldest first
    alu_result_t owed_results[$];
    // per issued request: whether a hand-written answer goes with it
    bit          row_fixed[$];
    alu_result_t row_answer[$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  stimulus_done  = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // golden arithmetic, computed directly at the block's widths
    function automatic alu_result_t alu_expected(alu_request_t r);
        alu_result_t   res;
        logic [DW-1:0] acc;
        logic [DW-1:0] base;
        logic [63:0]   rem_scaled;
        res = '0;
        case (r.opcode) inside
            uadp_pkg::OP_ADD: res.result_value = r.operand_a + r.operand_b;
            uadp_pkg::OP_SUB: res.result_value = r.operand_a - r.operand_b;
            uadp_pkg::OP_MUL: res.result_value = r.operand_a * r.operand_b;
            uadp_pkg::OP_DIV, uadp_pkg::OP_FRAC:
            begin
                if (r.operand_b == '0)
                begin
                    res.divide_by_zero = 1'b1;
                end
                else
                begin
                    res.result_value = r.operand_a / r.operand_b;
                    if (r.opcode == uadp_pkg::OP_FRAC)
                    begin
                        // remainder below divisor, so remainder * 2^32 fits in 64 bits
                        rem_scaled        = {32'(r.operand_a % r.operand_b), 32'd0};
                        res.fraction_part = FW'(rem_scaled / 64'(r.operand_b));
                    end
                end
            end
            uadp_pkg::OP_POW:
            begin
                acc  = 1;
                base = r.operand_a;
                for (int i = 0; i < DW; i++)
                begin
                    if (r.operand_b[i])
                        acc = acc * base;
                    base = base * base;
                end
                res.result_value = acc;
            end
            default: res = '0;
        endcase
        return res;
    endfunction

    // operand mix: corners, small values, single bits and full random words
    function automatic logic [DW-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 1;
            2:       return ALL_ONES;
            3:       return $urandom_range(0, 15);
            4:       return $urandom_range(0, 65535);
            5:       return 32'd1 << $urandom_range(0, DW - 1);
            6:       return ALL_ONES - $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    function automatic alu_request_t random_request();
        alu_request_t r;
        int           sel;
        r.operand_a = pick_operand();
        r.operand_b = pick_operand();
        sel = $urandom_range(0, 99);
        // power is slow, keep it to a modest share; spare opcodes now and then
        if (sel < 14)      r.opcode = uadp_pkg::OP_ADD;
        else if (sel < 28) r.opcode = uadp_pkg::OP_SUB;
        else if (sel < 44) r.opcode = uadp_pkg::OP_MUL;
        else if (sel < 62) r.opcode = uadp_pkg::OP_DIV;
        else if (sel < 80) r.opcode = uadp_pkg::OP_FRAC;
        else if (sel < 96) r.opcode = uadp_pkg::OP_POW;
        else if (sel < 98) r.opcode = OP_SPARE_6;
        else               r.opcode = OP_SPARE_7;
        // dividers get a share of small divisors so quotients have size
        if ((r.opcode == uadp_pkg::OP_DIV || r.opcode == uadp_pkg::OP_FRAC) &&
            $urandom_range(0, 2) == 0)
            r.operand_b = $urandom_range(1, 1000);
        return r;
    endfunction

    function automatic vector_row_t mk_row(logic [DW-1:0] a, logic [DW-1:0] b,
                                           logic [2:0] op, bit fixed,
                                           logic [DW-1:0] val, logic [FW-1:0] frac,
                                           logic dz);
        vector_row_t row;
        row.req    = '{operand_a: a, operand_b: b, opcode: op};
        row.fixed  = fixed;
        row.answer = '{result_value: val, fraction_part: frac, divide_by_zero: dz};
        return row;
    endfunction

    vector_row_t directed_rows[$];

    initial
    begin
        // wraparound at the extremes
        directed_rows.push_back(mk_row(ALL_ONES, 1, uadp_pkg::OP_ADD, 1, 0, 0, 0));
        directed_rows.push_back(mk_row(0, 0, uadp_pkg::OP_ADD, 1, 0, 0, 0));
        directed_rows.push_back(mk_row(0, 1, uadp_pkg::OP_SUB, 1, ALL_ONES, 0, 0));
        directed_rows.push_back(mk_row(ALL_ONES, ALL_ONES, uadp_pkg::OP_SUB, 1, 0, 0, 0));
        directed_rows.push_back(mk_row(ALL_ONES, ALL_ONES, uadp_pkg::OP_MUL, 1, 1, 0, 0));
        directed_rows.push_back(mk_row(32'h1234_5678, 32'h9abc_def0, uadp_pkg::OP_MUL,
                                       0, 0, 0, 0));
        // zero divisor in both divide modes
        directed_rows.push_back(mk_row(ALL_ONES, 0, uadp_pkg::OP_DIV, 1, 0, 0, 1));
        directed_rows.push_back(mk_row(32'd5, 0, uadp_pkg::OP_FRAC, 1, 0, 0, 1));
        directed_rows.push_back(mk_row(ALL_ONES, 1, uadp_pkg::OP_DIV, 1, ALL_ONES, 0, 0));
        directed_rows.push_back(mk_row(1, ALL_ONES, uadp_pkg::OP_DIV, 1, 0, 0, 0));
        directed_rows.push_back(mk_row(1, 3, uadp_pkg::OP_FRAC, 1, 0, 32'h5555_5555, 0));
        directed_rows.push_back(mk_row(7, 2, uadp_pkg::OP_FRAC, 1, 3, 32'h8000_0000, 0));
        directed_rows.push_back(mk_row(ALL_ONES - 1, ALL_ONES, uadp_pkg::OP_FRAC,
                                       0, 0, 0, 0));
        directed_rows.push_back(mk_row(ALL_ONES, 32'd7, uadp_pkg::OP_FRAC, 0, 0, 0, 0));
        // zero exponent, including zero to the zero
        directed_rows.push_back(mk_row(0, 0, uadp_pkg::OP_POW, 1, 1, 0, 0));
        directed_rows.push_back(mk_row(ALL_ONES, 0, uadp_pkg::OP_POW, 1, 1, 0, 0));
        directed_rows.push_back(mk_row(2, 31, uadp_pkg::OP_POW, 1, 32'h8000_0000, 0, 0));
        directed_rows.push_back(mk_row(2, 32, uadp_pkg::OP_POW, 1, 0, 0, 0));
        directed_rows.push_back(mk_row(3, ALL_ONES, uadp_pkg::OP_POW, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ALL_ONES, ALL_ONES, uadp_pkg::OP_POW, 0, 0, 0, 0));
        // spare opcodes give all zeros
        directed_rows.push_back(mk_row(ALL_ONES, ALL_ONES, OP_SPARE_6, 1, 0, 0, 0));
        directed_rows.push_back(mk_row(ALL_ONES, 0, OP_SPARE_7, 1, 0, 0, 0));
    end

    // sender side: bursts of back-to-back requests separated by idle gaps
    int burst_left = 0;

    task automatic send_request(alu_request_t r, bit fixed, alu_result_t answer);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                req_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        row_fixed.push_back(fixed);
        row_answer.push_back(answer);
        // ready only moves at the rising edge, so its value here holds at the next one
        while (!req_ch.ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].fixed,
                         directed_rows[i].answer);
        repeat (RANDOM_ITEMS)
            send_request(random_request(), 1'b0, '0);
        @(negedge clk);
        req_ch.valid <= 1'b0;
        stimulus_done = 1;
    end

    // receiver side: modes of always-ready, coin flips and long stalls
    int stall_mode = 0;
    int mode_left  = 0;

    initial rsp_ch.ready = 1'b0;

    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(5, 60);
        end
        mode_left--;
        case (stall_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= $urandom_range(0, 1);
            default: rsp_ch.ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // scoreboard: check results first, then log new requests at the same edge
    always @(posedge clk)
    begin
        alu_result_t exp_res;
        alu_result_t answer;
        bit          fixed;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (owed_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0t] unexpected result %h", $realtime, rsp_ch.payload);
            end
            else
            begin
                exp_res = owed_results.pop_front();
                if (rsp_ch.payload.result_value !== exp_res.result_value ||
                    rsp_ch.payload.fraction_part !== exp_res.fraction_part ||
                    rsp_ch.payload.divide_by_zero !== exp_res.divide_by_zero)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] result mismatch: value %h/%h frac %h/%h dz %b/%b",
                                 $realtime,
                                 exp_res.result_value, rsp_ch.payload.result_value,
                                 exp_res.fraction_part, rsp_ch.payload.fraction_part,
                                 exp_res.divide_by_zero, rsp_ch.payload.divide_by_zero);
                end
            end
        end
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            fixed  = row_fixed.pop_front();
            answer = row_answer.pop_front();
            owed_results.push_back(fixed ? answer : alu_expected(req_ch.payload));
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // end of run: drain, let the engine settle, then report
    initial
    begin
        wait (stimulus_done);
        wait (owed_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (owed_results.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/uadp_pkg.sv
rtl/uadp_if.sv
rtl/uadp_mul.sv
rtl/uadp_div.sv
rtl/unsigned_alu_div_pow_top.sv
test/unsigned_alu_div_pow_top_tb.sv
